@@ design/hlsa_pkg.sv @@
// shared constants, types and helper functions for the hsl lightness step adjuster
// no dependencies; imported by every module of the block

package hlsa_pkg;

  localparam int F       = 16;
  localparam int ONE     = 1 << F;
  localparam int ONE_W   = F + 1;
  localparam int DEN_W   = F + 2;
  localparam int NUM_W   = ONE_W + F;
  localparam int QW      = F + 1;
  localparam int W       = F + 8;
  localparam int PW      = 2 * W;
  localparam int H6_W    = F + 3;

  localparam int DIV6_SHIFT = H6_W + 3;
  localparam int DIV6_MUL   = ((1 << DIV6_SHIFT) + 5) / 6;
  localparam int M_W        = DIV6_SHIFT - 2;

  localparam int ONE_THIRD  = ONE / 3;
  localparam int TWO_THIRDS = (2 * ONE) / 3;

  localparam int LATENCY = QW + 8;

  localparam logic [1:0] KIND_LIGHTER = 2'd0;
  localparam logic [1:0] KIND_DARKER  = 2'd1;
  localparam logic [1:0] KIND_LEVEL   = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef logic signed [W-1:0] sw_t;
  typedef logic [ONE_W-1:0]    fx_t;

  // c * ONE / 255 for a byte, exact at sixteen fraction bits
  function automatic fx_t to_fix(input logic [7:0] c);
    return fx_t'({c, c}) + fx_t'(c == 8'hFF);
  endfunction

  // lightness ONE - (k+1)*ONE/11 for step k
  function automatic fx_t step_lum(input logic [3:0] k);
    fx_t v;
    unique case (k)
      4'd0:    v = fx_t'(ONE - (1 * ONE) / 11);
      4'd1:    v = fx_t'(ONE - (2 * ONE) / 11);
      4'd2:    v = fx_t'(ONE - (3 * ONE) / 11);
      4'd3:    v = fx_t'(ONE - (4 * ONE) / 11);
      4'd4:    v = fx_t'(ONE - (5 * ONE) / 11);
      4'd5:    v = fx_t'(ONE - (6 * ONE) / 11);
      4'd6:    v = fx_t'(ONE - (7 * ONE) / 11);
      4'd7:    v = fx_t'(ONE - (8 * ONE) / 11);
      4'd8:    v = fx_t'(ONE - (9 * ONE) / 11);
      4'd9:    v = fx_t'(ONE - (10 * ONE) / 11);
      default: v = fx_t'(ONE - (11 * ONE) / 11);
    endcase
    return v;
  endfunction

endpackage

@@ design/hlsa_div.sv @@
// pipelined restoring divider, one quotient bit per register stage
// computes (in_num << F) / in_den; depends on hlsa_pkg

module hlsa_div (
  input  logic                         clk,
  input  hlsa_pkg::fx_t                in_num,
  input  logic [hlsa_pkg::DEN_W-1:0]   in_den,
  output logic [hlsa_pkg::QW-1:0]      out_quo
);
  import hlsa_pkg::*;

  logic [NUM_W-1:0] rem_r [QW];
  logic [NUM_W-1:0] rem_nxt [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [DEN_W-1:0] den_nxt [QW];
  logic [QW-1:0]    quo_r [QW];
  logic [QW-1:0]    quo_nxt [QW];

  always_comb begin
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    quo_in;
    logic [NUM_W:0]   dsh;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rem_in = {in_num, {F{1'b0}}};
        den_in = in_den;
        quo_in = '0;
      end else begin
        rem_in = rem_r[j-1];
        den_in = den_r[j-1];
        quo_in = quo_r[j-1];
      end
      dsh = (NUM_W + 1)'(den_in) << (QW - 1 - j);
      if ({1'b0, rem_in} >= dsh) begin
        rem_nxt[j] = NUM_W'({1'b0, rem_in} - dsh);
        quo_nxt[j] = quo_in | (QW'(1) << (QW - 1 - j));
      end else begin
        rem_nxt[j] = rem_in;
        quo_nxt[j] = quo_in;
      end
      den_nxt[j] = den_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      rem_r[j] <= rem_nxt[j];
      den_r[j] <= den_nxt[j];
      quo_r[j] <= quo_nxt[j];
    end
  end

  assign out_quo = quo_r[QW-1];

endmodule

@@ design/hlsa_chan.sv @@
// one output channel: piecewise hue function and conversion to a byte, two stages
// depends on hlsa_pkg

module hlsa_chan (
  input  logic          clk,
  input  hlsa_pkg::sw_t in_lo,
  input  hlsa_pkg::sw_t in_hi,
  input  hlsa_pkg::sw_t in_t,
  output logic [7:0]    out_byte
);
  import hlsa_pkg::*;

  typedef enum logic [1:0] {BR_RISE, BR_HIGH, BR_FALL, BR_LOW} br_t;

  localparam int T_RISE = (ONE + 5) / 6;
  localparam int T_HIGH = (ONE + 1) / 2;
  localparam int T_FALL = (2 * ONE + 2) / 3;

  br_t               br_r, br_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  sw_t               lo_r, hi_r;
  logic [7:0]        byte_r, byte_nxt;

  always_comb begin
    sw_t fac;
    sw_t diff;
    diff = in_hi - in_lo;
    if (in_t < sw_t'(T_RISE)) begin
      br_nxt = BR_RISE;
      fac = (in_t <<< 2) + (in_t <<< 1);
    end else if (in_t < sw_t'(T_HIGH)) begin
      br_nxt = BR_HIGH;
      fac = '0;
    end else if (in_t < sw_t'(T_FALL)) begin
      br_nxt = BR_FALL;
      fac = ((sw_t'(TWO_THIRDS) - in_t) <<< 2) + ((sw_t'(TWO_THIRDS) - in_t) <<< 1);
    end else begin
      br_nxt = BR_LOW;
      fac = '0;
    end
    prod_nxt = PW'(diff) * PW'(fac);
  end

  always_comb begin
    sw_t val;
    logic signed [W+8:0] scaled;
    logic signed [W+8:0] c;
    unique case (br_r)
      BR_RISE, BR_FALL: val = lo_r + sw_t'(prod_r >>> F);
      BR_HIGH:          val = hi_r;
      default:          val = lo_r;
    endcase
    scaled = ((W + 9)'(val) <<< 8) - (W + 9)'(val);
    c = scaled >>> F;
    if (val < 0) begin
      byte_nxt = 8'd0;
    end else if (c > 255) begin
      byte_nxt = 8'd255;
    end else begin
      byte_nxt = c[7:0];
    end
  end

  always_ff @(posedge clk) begin
    br_r   <= br_nxt;
    prod_r <= prod_nxt;
    lo_r   <= in_lo;
    hi_r   <= in_hi;
    byte_r <= byte_nxt;
  end

  assign out_byte = byte_r;

endmodule

@@ design/hsl_lightness_step_adjust_core.sv @@
// top level: rgb to hsl, lightness step adjust and rebuild of one argb pixel
// each start transfer gives one out_strobe cycle that carries its result
// throughput one pixel per cycle; busy stays low, results cannot be held off
// the pipeline depth is set chiefly by the two 17-stage dividers for saturation and hue
// synchronous active-low reset clears the valid bits; data registers are not reset
// depends on hlsa_pkg, hlsa_div, hlsa_chan

module hsl_lightness_step_adjust_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_amount,
  input  logic [31:0] in_pixel,
  output logic        out_strobe,
  output logic [31:0] out_result_pixel
);
  import hlsa_pkg::*;

  localparam logic [7:0] LVL_ONE   = 8'd10;
  localparam logic [7:0] LVL_TWO   = 8'd11;
  localparam logic [7:0] LVL_FOUR  = 8'd12;
  localparam logic [7:0] LVL_SEVEN = 8'd13;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      amount;
    logic [31:0]     pixel;
    fx_t             lum;
    logic            grey;
    logic            neg;
    logic [H6_W-1:0] hoff;
  } side_t;

  function automatic sw_t wrap(input sw_t t);
    sw_t v;
    v = t;
    if (v < 0) v = sw_t'(v + sw_t'(ONE));
    if (v > sw_t'(ONE)) v = sw_t'(v - sw_t'(ONE));
    return v;
  endfunction

  // stage 1: channels, max/min, lightness, divider operands
  side_t            side1_nxt, side1_r;
  fx_t              ns1_nxt, ns1_r, nh1_nxt, nh1_r;
  logic [DEN_W-1:0] ds1_nxt, ds1_r, dh1_nxt, dh1_r;
  logic             vld1_r;

  always_comb begin
    fx_t r, g, b, mx, mn, d;
    logic [DEN_W-1:0] sum;
    r = to_fix(in_pixel[23:16]);
    g = to_fix(in_pixel[15:8]);
    b = to_fix(in_pixel[7:0]);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = DEN_W'(mx) + DEN_W'(mn);
    side1_nxt.kind   = in_kind;
    side1_nxt.amount = in_amount;
    side1_nxt.pixel  = in_pixel;
    side1_nxt.lum    = fx_t'(sum >> 1);
    side1_nxt.grey   = (d == '0);
    if (mx == r) begin
      side1_nxt.neg  = (g < b);
      nh1_nxt        = (g < b) ? b - g : g - b;
      side1_nxt.hoff = (g < b) ? H6_W'(6 * ONE) : '0;
    end else if (mx == g) begin
      side1_nxt.neg  = (b < r);
      nh1_nxt        = (b < r) ? r - b : b - r;
      side1_nxt.hoff = H6_W'(2 * ONE);
    end else begin
      side1_nxt.neg  = (r < g);
      nh1_nxt        = (r < g) ? g - r : r - g;
      side1_nxt.hoff = H6_W'(4 * ONE);
    end
    ns1_nxt = d;
    if (d == '0) begin
      ds1_nxt = DEN_W'(ONE);
      dh1_nxt = DEN_W'(ONE);
    end else begin
      ds1_nxt = (side1_nxt.lum > fx_t'(ONE / 2)) ? DEN_W'(2 * ONE) - sum : sum;
      dh1_nxt = DEN_W'(d);
    end
  end

  // divider alignment
  logic [QW-1:0] quo_s, quo_h;
  side_t         sd_r [QW];
  logic [QW-1:0] vd_r;

  hlsa_div u_div_sat (.clk(clk), .in_num(ns1_r), .in_den(ds1_r), .out_quo(quo_s));
  hlsa_div u_div_hue (.clk(clk), .in_num(nh1_r), .in_den(dh1_r), .out_quo(quo_h));

  // stage 2: hue sixths and the multiply for the division by six
  side_t                 side2_r;
  fx_t                   s2_nxt, s2_r;
  logic [H6_W+M_W-1:0]   hp2_nxt, hp2_r;

  always_comb begin
    logic [H6_W-1:0] h6;
    side_t sd;
    sd = sd_r[QW-1];
    if (sd.grey) begin
      s2_nxt = '0;
      h6 = '0;
    end else begin
      s2_nxt = fx_t'(quo_s);
      h6 = sd.neg ? sd.hoff - H6_W'(quo_h) : sd.hoff + H6_W'(quo_h);
    end
    hp2_nxt = (H6_W + M_W)'(h6) * (H6_W + M_W)'(DIV6_MUL);
  end

  // stage 3: step quantization and new lightness
  fx_t         h3_nxt, h3_r, s3_r, l3_nxt, l3_r;
  logic        pass3_nxt, pass3_r;
  logic [31:0] pix3_r;

  always_comb begin
    logic [ONE_W+3:0] tmp;
    logic [ONE_W+3:0] rnd;
    logic [3:0]       base;
    logic [3:0]       st;
    logic [8:0]       dsum;
    logic             inrange;
    h3_nxt = fx_t'(hp2_r >> DIV6_SHIFT);
    tmp = (ONE_W + 4)'(fx_t'(ONE) - side2_r.lum) * (ONE_W + 4)'(11);
    inrange = (tmp >= (ONE_W + 4)'(ONE / 2)) && (tmp < (ONE_W + 4)'((21 * ONE) / 2));
    rnd = (tmp + (ONE_W + 4)'(ONE / 2)) >> F;
    base = rnd[3:0] - 4'd1;
    dsum = 9'(base) + 9'(side2_r.amount);
    st = 4'd0;
    pass3_nxt = 1'b0;
    unique case (side2_r.kind)
      KIND_LIGHTER: begin
        st = ({4'd0, base} < side2_r.amount) ? 4'd0
           : 4'(8'(base) - side2_r.amount + 8'd1);
        pass3_nxt = !inrange;
      end
      KIND_DARKER: begin
        st = (dsum > 9'd9) ? 4'd9 : dsum[3:0];
        pass3_nxt = !inrange;
      end
      KIND_LEVEL: begin
        unique case (side2_r.amount)
          LVL_ONE:   st = 4'd1;
          LVL_TWO:   st = 4'd2;
          LVL_FOUR:  st = 4'd4;
          LVL_SEVEN: st = 4'd7;
          default:   st = 4'd5;
        endcase
      end
      default: pass3_nxt = 1'b1;
    endcase
    l3_nxt = step_lum(st);
  end

  // stage 4: lightness times (one plus saturation) below half lightness, else lightness times saturation
  logic [ONE_W+DEN_W-1:0] p4_nxt, p4_r;
  logic                   lo4_r;
  fx_t                    l4_r, s4_r, h4_r;
  logic                   pass4_r;
  logic [31:0]            pix4_r;
  logic                   lo4_nxt;

  always_comb begin
    logic [DEN_W-1:0] opb;
    lo4_nxt = (l3_r < fx_t'(ONE / 2));
    opb = lo4_nxt ? DEN_W'(ONE) + DEN_W'(s3_r) : DEN_W'(s3_r);
    p4_nxt = (ONE_W + DEN_W)'(l3_r) * (ONE_W + DEN_W)'(opb);
  end

  // stage 5: v1, v2 and the three hue arguments
  sw_t         lo5_nxt, lo5_r, hi5_nxt, hi5_r;
  sw_t         t5_nxt [3];
  sw_t         t5_r [3];
  logic        pass5_r;
  logic [31:0] pix5_r;

  always_comb begin
    sw_t ps, hw;
    ps = sw_t'(p4_r >> F);
    hi5_nxt = lo4_r ? ps : sw_t'(l4_r) + sw_t'(s4_r) - ps;
    lo5_nxt = (sw_t'(l4_r) <<< 1) - hi5_nxt;
    hw = sw_t'(h4_r);
    t5_nxt[0] = wrap(sw_t'(hw + sw_t'(ONE_THIRD)));
    t5_nxt[1] = wrap(hw);
    t5_nxt[2] = wrap(sw_t'(hw - sw_t'(ONE_THIRD)));
  end

  logic [7:0] ch_byte [3];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    hlsa_chan u_chan (
      .clk     (clk),
      .in_lo   (lo5_r),
      .in_hi   (hi5_r),
      .in_t    (t5_r[k]),
      .out_byte(ch_byte[k])
    );
  end

  logic        pass6_r, pass7_r;
  logic [31:0] pix6_r, pix7_r;
  logic        vld2_r, vld3_r, vld4_r, vld5_r, vld6_r, vld7_r;
  logic        out_strobe_r;
  logic [31:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r       <= 1'b0;
      vd_r         <= '0;
      vld2_r       <= 1'b0;
      vld3_r       <= 1'b0;
      vld4_r       <= 1'b0;
      vld5_r       <= 1'b0;
      vld6_r       <= 1'b0;
      vld7_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      vld1_r       <= start;
      vd_r         <= {vd_r[QW-2:0], vld1_r};
      vld2_r       <= vd_r[QW-1];
      vld3_r       <= vld2_r;
      vld4_r       <= vld3_r;
      vld5_r       <= vld4_r;
      vld6_r       <= vld5_r;
      vld7_r       <= vld6_r;
      out_strobe_r <= vld7_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= side1_nxt;
    ns1_r   <= ns1_nxt;
    nh1_r   <= nh1_nxt;
    ds1_r   <= ds1_nxt;
    dh1_r   <= dh1_nxt;
    sd_r[0] <= side1_r;
    for (int j = 1; j < QW; j++) begin
      sd_r[j] <= sd_r[j-1];
    end
    side2_r <= sd_r[QW-1];
    s2_r    <= s2_nxt;
    hp2_r   <= hp2_nxt;
    h3_r    <= h3_nxt;
    s3_r    <= s2_r;
    l3_r    <= l3_nxt;
    pass3_r <= pass3_nxt;
    pix3_r  <= side2_r.pixel;
    p4_r    <= p4_nxt;
    lo4_r   <= lo4_nxt;
    l4_r    <= l3_r;
    s4_r    <= s3_r;
    h4_r    <= h3_r;
    pass4_r <= pass3_r;
    pix4_r  <= pix3_r;
    lo5_r   <= lo5_nxt;
    hi5_r   <= hi5_nxt;
    for (int k = 0; k < 3; k++) begin
      t5_r[k] <= t5_nxt[k];
    end
    pass5_r <= pass4_r;
    pix5_r  <= pix4_r;
    pass6_r <= pass5_r;
    pix6_r  <= pix5_r;
    pass7_r <= pass6_r;
    pix7_r  <= pix6_r;
    out_pix_r <= pass7_r ? pix7_r : {pix7_r[31:24], ch_byte[0], ch_byte[1], ch_byte[2]};
  end

  assign busy             = 1'b0;
  assign out_strobe       = out_strobe_r;
  assign out_result_pixel = out_pix_r;

endmodule

@@ design/hlsa_chk.sv @@
// port-level checks for the hsl lightness step adjuster, bound to the top level
// depends on hlsa_pkg and hsl_lightness_step_adjust_core

module hlsa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_kind,
  input logic [31:0] in_pixel,
  input logic        out_strobe,
  input logic [31:0] out_result_pixel
);
  import hlsa_pkg::*;

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe right after reset");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("transfer produced no result");

  a_result_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a transfer");

  a_alpha_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_result_pixel[31:24] == $past(in_pixel[31:24], LATENCY))
    else $error("alpha byte changed");

  a_unused_kind_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_kind, LATENCY) == KIND_NONE)
      |-> out_result_pixel == $past(in_pixel, LATENCY))
    else $error("unused kind did not pass the pixel through");

endmodule

bind hsl_lightness_step_adjust_core hlsa_chk u_hlsa_chk (.*);
